FILE: rtl/core/kcp_pkg.sv
package kcp_pkg;

  localparam int FRAC_BITS = 32;
  localparam int DW = 64;
  localparam int STD_W = 63;
  localparam int NS = 8;
  localparam int IDX_W = $clog2(NS);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH = NS * NS;
  localparam int CFG_IDX_W = 3;
  localparam int NGRP = 4;
  localparam int GRP_W = $clog2(NGRP);
  localparam int SQ_STEPS = (DW + FRAC_BITS + 1) / 2;

  localparam logic signed [DW-1:0] ONE = DW'(1) << FRAC_BITS;
  localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_POS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_VEL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_BIAS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_FREQ = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_SCALE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_CORR   = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PST,
    ST_PWT,
    ST_CLR,
    ST_MRD,
    ST_MST,
    ST_MWT,
    ST_MWR,
    ST_SRD,
    ST_SST,
    ST_SWT,
    ST_OUT
  } kcp_state_t;

  function automatic logic signed [DW-1:0] sadd(logic signed [DW-1:0] a,
                                                logic signed [DW-1:0] b);
    logic signed [DW-1:0] s;
    s = a + b;
    if (a[DW-1] == b[DW-1] && s[DW-1] != a[DW-1]) return a[DW-1] ? SMIN : SMAX;
    return s;
  endfunction

  function automatic logic signed [DW-1:0] ssub(logic signed [DW-1:0] a,
                                                logic signed [DW-1:0] b);
    logic signed [DW-1:0] d;
    d = a - b;
    if (a[DW-1] != b[DW-1] && d[DW-1] != a[DW-1]) return a[DW-1] ? SMIN : SMAX;
    return d;
  endfunction

  function automatic logic [DW-1:0] mag(logic signed [DW-1:0] a);
    return a[DW-1] ? (~a + DW'(1)) : a;
  endfunction

endpackage

FILE: rtl/core/kcp_in_if.sv
interface kcp_in_if import kcp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic [STD_W-1:0]        init_pos_std;
  logic [STD_W-1:0]        init_vel_std;
  logic [STD_W-1:0]        init_bias_std;
  logic [STD_W-1:0]        init_freq_std;
  logic [STD_W-1:0]        init_scale;
  logic signed [DW-1:0]    freq_noise;

  modport source(output valid, action, init_pos_std, init_vel_std, init_bias_std,
                 init_freq_std, init_scale, freq_noise, input ready);
  modport sink(input valid, action, init_pos_std, init_vel_std, init_bias_std,
               init_freq_std, init_scale, freq_noise, output ready);
endinterface

FILE: rtl/core/kcp_out_if.sv
interface kcp_out_if import kcp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STD_W-1:0]     std_position;
  logic [STD_W-1:0]     std_velocity;
  logic [STD_W-1:0]     std_clock_bias;
  logic signed [DW-1:0] clock_bias_error;

  modport source(output valid, std_position, std_velocity, std_clock_bias,
                 clock_bias_error, input ready);
  modport sink(input valid, std_position, std_velocity, std_clock_bias,
               clock_bias_error, output ready);
endinterface

FILE: rtl/core/kcp_cfg_if.sv
interface kcp_cfg_if import kcp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [STD_W-1:0]     data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/core/kcp_ram.sv
module kcp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/kcp_fmul.sv
module kcp_fmul import kcp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [DW-1:0] a,
  input  logic signed [DW-1:0] b,
  output logic                 done,
  output logic signed [DW-1:0] res
);

  localparam int HW = DW / 2;
  localparam int PW = 2 * DW;
  localparam logic [2:0] MUL_PARTS = 3'd4;
  localparam logic [PW-1:0] RND = PW'(1) << (FRAC_BITS - 1);

  logic [DW-1:0] ma_r, mb_r;
  logic          neg_r;
  logic [PW-1:0] prod_r;
  logic [2:0]    cnt_r;
  logic          busy_r, done_r;
  logic signed [DW-1:0] res_r;

  logic [HW-1:0] op_a, op_b;
  logic [DW-1:0] pp;
  logic [PW-1:0] pp_sh;
  logic [PW-1:0] rnd;
  logic          ovf;
  logic [DW-1:0] mid, lim, mres;

  // One 32x32 partial product per cycle, weighted by the halves it covers.
  always_comb begin
    op_a  = cnt_r[1] ? ma_r[DW-1:HW] : ma_r[HW-1:0];
    op_b  = cnt_r[0] ? mb_r[DW-1:HW] : mb_r[HW-1:0];
    pp    = op_a * op_b;
    pp_sh = {{DW{1'b0}}, pp} << {cnt_r[1] & cnt_r[0], cnt_r[1] ^ cnt_r[0], 5'b0};
    rnd   = prod_r + RND;
    ovf   = |rnd[PW-1:FRAC_BITS+DW];
    mid   = rnd[FRAC_BITS+DW-1:FRAC_BITS];
    lim   = neg_r ? SMIN : SMAX;
    mres  = (ovf || mid > lim) ? lim : mid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        ma_r   <= mag(a);
        mb_r   <= mag(b);
        neg_r  <= a[DW-1] ^ b[DW-1];
        prod_r <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (cnt_r == MUL_PARTS) begin
          res_r  <= neg_r ? -mres : mres;
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end else begin
          prod_r <= prod_r + pp_sh;
          cnt_r  <= cnt_r + 3'd1;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

FILE: rtl/core/kcp_sqrt.sv
module kcp_sqrt import kcp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [DW-1:0] x,
  output logic                 done,
  output logic [STD_W-1:0]     root
);

  localparam int NW = 2 * SQ_STEPS;
  localparam int RW = SQ_STEPS + 2;
  localparam int CW = $clog2(SQ_STEPS + 1);
  localparam logic [CW-1:0] LAST = CW'(SQ_STEPS - 1);

  logic [NW-1:0]       n_r;
  logic [RW-1:0]       rem_r;
  logic [SQ_STEPS-1:0] root_r;
  logic [CW-1:0]       cnt_r;
  logic                busy_r, done_r;

  logic [RW-1:0] rem_sh, trial;
  logic          fits;

  // Restoring square root, two radicand bits per cycle.
  always_comb begin
    rem_sh = {rem_r[SQ_STEPS-1:0], n_r[NW-1:NW-2]};
    trial  = {root_r, 2'b01};
    fits   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        n_r    <= (x > 0) ? ({{(NW-DW){1'b0}}, x} << FRAC_BITS) : '0;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        n_r    <= n_r << 2;
        rem_r  <= fits ? rem_sh - trial : rem_sh;
        root_r <= {root_r[SQ_STEPS-2:0], fits};
        cnt_r  <= cnt_r + CW'(1);
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = STD_W'(root_r);

endmodule

FILE: rtl/core/kalman_covariance_propagate.sv
// An init item and a propagate item both run on the single shared 64x64 fixed-point
// multiplier and the two-bit-per-cycle square root unit, which is run three times.
// Throughput: one item at a time; a new item is taken once the previous one is done.
// Reset clears the control, configuration and bias registers and puts the state in the
// clear sweep, which writes zeros through the stored covariance; no item is taken then.
module kalman_covariance_propagate import kcp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  kcp_in_if.sink      in_chan,
  kcp_out_if.source   out_chan,
  kcp_cfg_if.sink     cfg_chan
);

  kcp_state_t state_r, state_nxt;

  logic [STD_W-1:0] noise_pos_r, noise_vel_r, noise_bias_r, noise_freq_r;
  logic [STD_W-1:0] noise_scale_r, step_time_r, inv_corr_r;

  logic             prop_r;
  logic [STD_W-1:0] istd_r [NGRP];
  logic [STD_W-1:0] iscale_r;
  logic signed [DW-1:0] fn_r;

  logic [2:0]       step_r;
  logic [GRP_W-1:0] grp_r;
  logic [1:0]       sub_r;
  logic [IDX_W-1:0] i_r, j_r;
  logic             term_r, phase_r, zap_r;
  logic [1:0]       sq_r;

  logic signed [DW-1:0] acc_r, x_r, dt2h_r, tmp_r, phi67_r, phi77_r;
  logic signed [DW-1:0] qh_r [NGRP];
  logic signed [DW-1:0] bias_r, prev_r;
  logic [STD_W-1:0]     std_r [3];

  logic                 out_valid_r;
  logic [STD_W-1:0]     out_pos_r, out_vel_r, out_clk_r;
  logic signed [DW-1:0] out_bias_r;

  localparam logic [2:0] GROUP_STEP = 3'd6;
  localparam logic [1:0] SQ_LAST = 2'd2;

  logic signed [DW-1:0] dt, half, cc, fscale, std_sel, qh_sel;
  logic [IDX_W-1:0]     r_sel, k_sel;
  logic [GRP_W-1:0]     q_idx;
  logic                 in_xfer, mul_start, mul_done, sq_start, sq_done;
  logic signed [DW-1:0] mul_a, mul_b, mul_res, sq_x;
  logic [STD_W-1:0]     sq_root;
  logic                 group_last, mat_last;

  logic                 p_we, t_we;
  logic [ADDR_W-1:0]    p_waddr, p_raddr, t_waddr, t_raddr;
  logic signed [DW-1:0] p_wdata, t_wdata, p_rdata, t_rdata, m_val, diag_val, wb_val;

  function automatic logic [GRP_W-1:0] grp_of(logic [IDX_W-1:0] r);
    if (r < 3'd3) return 2'd0;
    if (r < 3'd6) return 2'd1;
    if (r == 3'd6) return 2'd2;
    return 2'd3;
  endfunction

  function automatic logic has_partner(logic [IDX_W-1:0] r);
    return (r < 3'd3) || (r == 3'd6);
  endfunction

  function automatic logic [IDX_W-1:0] partner(logic [IDX_W-1:0] r);
    return (r == 3'd6) ? 3'd7 : r + 3'd3;
  endfunction

  function automatic logic signed [DW-1:0] phi_at(logic [IDX_W-1:0] r, logic [IDX_W-1:0] k,
                                                  logic signed [DW-1:0] dtv,
                                                  logic signed [DW-1:0] p67,
                                                  logic signed [DW-1:0] p77);
    if (r == k) return (r == 3'd7) ? p77 : ONE;
    if (r == 3'd6) return p67;
    return dtv;
  endfunction

  kcp_fmul u_fmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  kcp_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .x     (sq_x),
    .done  (sq_done),
    .root  (sq_root)
  );

  kcp_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_p_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  kcp_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_t_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign in_xfer        = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid            = out_valid_r;
  assign out_chan.std_position     = out_pos_r;
  assign out_chan.std_velocity     = out_vel_r;
  assign out_chan.std_clock_bias   = out_clk_r;
  assign out_chan.clock_bias_error = out_bias_r;

  always_comb begin
    dt      = {1'b0, step_time_r};
    half    = dt >>> 1;
    cc      = {1'b0, inv_corr_r};
    fscale  = sadd({1'b0, prop_r ? noise_scale_r : iscale_r}, ONE);
    unique case (grp_r)
      2'd0:    std_sel = {1'b0, prop_r ? noise_pos_r : istd_r[0]};
      2'd1:    std_sel = {1'b0, prop_r ? noise_vel_r : istd_r[1]};
      2'd2:    std_sel = {1'b0, prop_r ? noise_bias_r : istd_r[2]};
      default: std_sel = {1'b0, prop_r ? noise_freq_r : istd_r[3]};
    endcase
    r_sel    = phase_r ? j_r : i_r;
    k_sel    = term_r ? partner(r_sel) : r_sel;
    q_idx    = (state_r == ST_MST) ? grp_of(k_sel) : grp_of(i_r);
    qh_sel   = qh_r[q_idx];
    // Process noise enters the first product on the diagonal only.
    m_val    = (k_sel == j_r) ? sadd(p_rdata, qh_sel) : p_rdata;
    diag_val = (i_r == j_r) ? qh_sel : '0;
    wb_val   = (i_r == j_r) ? sadd(acc_r, qh_sel) : acc_r;
    group_last = (step_r == GROUP_STEP) && (grp_r == 2'd3) &&
                 (prop_r ? (sub_r == 2'd2) : (sub_r == 2'd1));
    mat_last   = (i_r == 3'd7) && (j_r == 3'd7);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_xfer) state_nxt = ST_PST;
      ST_PST:  state_nxt = ST_PWT;
      ST_PWT: begin
        if (mul_done) state_nxt = group_last ? (prop_r ? ST_MRD : ST_CLR) : ST_PST;
      end
      ST_CLR: begin
        if (mat_last) state_nxt = zap_r ? ST_IDLE : ST_SRD;
      end
      ST_MRD:  state_nxt = ST_MST;
      ST_MST:  state_nxt = ST_MWT;
      ST_MWT: begin
        if (mul_done) state_nxt = (!term_r && has_partner(r_sel)) ? ST_MRD : ST_MWR;
      end
      ST_MWR:  state_nxt = (mat_last && phase_r) ? ST_SRD : ST_MRD;
      ST_SRD:  state_nxt = ST_SST;
      ST_SST:  state_nxt = ST_SWT;
      ST_SWT: begin
        if (sq_done) state_nxt = (sq_r == SQ_LAST) ? ST_OUT : ST_SRD;
      end
      ST_OUT: begin
        if (!out_valid_r || out_chan.ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Unit operands and memory controls.
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    sq_start  = (state_r == ST_SST);
    sq_x      = p_rdata;
    p_we      = 1'b0;
    p_waddr   = {i_r, j_r};
    p_wdata   = zap_r ? '0 : diag_val;
    t_we      = 1'b0;
    t_waddr   = {i_r, j_r};
    t_wdata   = acc_r;
    t_raddr   = {i_r, k_sel};
    p_raddr   = {k_sel, j_r};
    unique case (state_r)
      ST_PST: begin
        mul_start = 1'b1;
        unique case (step_r)
          3'd0: begin mul_a = sadd(fn_r, prev_r); mul_b = half; end
          3'd1: begin mul_a = dt; mul_b = dt; end
          3'd2: begin mul_a = cc; mul_b = dt2h_r; end
          3'd3: begin mul_a = cc; mul_b = dt; end
          3'd4: begin mul_a = cc; mul_b = cc; end
          3'd5: begin mul_a = x_r; mul_b = dt2h_r; end
          default: begin
            unique case (sub_r)
              2'd0:    begin mul_a = std_sel; mul_b = fscale; end
              2'd1:    begin mul_a = x_r; mul_b = x_r; end
              default: begin mul_a = x_r; mul_b = half; end
            endcase
          end
        endcase
      end
      ST_CLR: p_we = 1'b1;
      ST_MST: begin
        mul_start = 1'b1;
        if (phase_r) begin
          mul_a = t_rdata;
          mul_b = phi_at(j_r, k_sel, dt, phi67_r, phi77_r);
        end else begin
          mul_a = phi_at(i_r, k_sel, dt, phi67_r, phi77_r);
          mul_b = m_val;
        end
      end
      ST_MWR: begin
        p_we    = phase_r;
        t_we    = !phase_r;
        p_wdata = wb_val;
      end
      ST_SRD, ST_SST, ST_SWT: begin
        unique case (sq_r)
          2'd0:    p_raddr = ADDR_W'(0);
          2'd1:    p_raddr = ADDR_W'(3 * (NS + 1));
          default: p_raddr = ADDR_W'(6 * (NS + 1));
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_pos_r   <= '0;
      noise_vel_r   <= '0;
      noise_bias_r  <= '0;
      noise_freq_r  <= '0;
      noise_scale_r <= '0;
      step_time_r   <= '0;
      inv_corr_r    <= '0;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      unique case (cfg_chan.index)
        CFG_NOISE_POS:   noise_pos_r   <= cfg_chan.data;
        CFG_NOISE_VEL:   noise_vel_r   <= cfg_chan.data;
        CFG_NOISE_BIAS:  noise_bias_r  <= cfg_chan.data;
        CFG_NOISE_FREQ:  noise_freq_r  <= cfg_chan.data;
        CFG_NOISE_SCALE: noise_scale_r <= cfg_chan.data;
        CFG_STEP_TIME:   step_time_r   <= cfg_chan.data;
        CFG_INV_CORR:    inv_corr_r    <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zap_r       <= 1'b1;
      i_r         <= '0;
      j_r         <= '0;
      term_r      <= 1'b0;
      phase_r     <= 1'b0;
      sq_r        <= '0;
      step_r      <= '0;
      grp_r       <= '0;
      sub_r       <= '0;
      bias_r      <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
      prop_r      <= 1'b0;
    end else begin
      if (out_valid_r && out_chan.ready && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            prop_r    <= in_chan.action;
            istd_r[0] <= in_chan.init_pos_std;
            istd_r[1] <= in_chan.init_vel_std;
            istd_r[2] <= in_chan.init_bias_std;
            istd_r[3] <= in_chan.init_freq_std;
            iscale_r  <= in_chan.init_scale;
            fn_r      <= in_chan.freq_noise;
            step_r    <= in_chan.action ? 3'd0 : GROUP_STEP;
            grp_r     <= '0;
            sub_r     <= '0;
            i_r       <= '0;
            j_r       <= '0;
            term_r    <= 1'b0;
            phase_r   <= 1'b0;
            sq_r      <= '0;
          end
        end
        ST_PWT: begin
          if (mul_done) begin
            unique case (step_r)
              3'd0: begin
                bias_r <= sadd(bias_r, mul_res);
                prev_r <= fn_r;
              end
              3'd1: dt2h_r  <= mul_res >>> 1;
              3'd2: phi67_r <= ssub(dt, mul_res);
              3'd3: tmp_r   <= ssub(ONE, mul_res);
              3'd4: x_r     <= mul_res;
              3'd5: phi77_r <= sadd(tmp_r, mul_res);
              default: ;
            endcase
            if (step_r != GROUP_STEP) begin
              step_r <= step_r + 3'd1;
            end else if ((sub_r == 2'd2) || (!prop_r && sub_r == 2'd1)) begin
              qh_r[grp_r] <= mul_res;
              sub_r       <= '0;
              grp_r       <= grp_r + 2'd1;
            end else begin
              x_r   <= mul_res;
              sub_r <= sub_r + 2'd1;
            end
          end
        end
        ST_CLR: begin
          {i_r, j_r} <= {i_r, j_r} + ADDR_W'(1);
          if (mat_last) zap_r <= 1'b0;
        end
        ST_MWT: begin
          if (mul_done) begin
            acc_r  <= term_r ? sadd(acc_r, mul_res) : mul_res;
            term_r <= !term_r && has_partner(r_sel);
          end
        end
        ST_MWR: begin
          term_r     <= 1'b0;
          {i_r, j_r} <= {i_r, j_r} + ADDR_W'(1);
          if (mat_last) phase_r <= 1'b1;
        end
        ST_SWT: begin
          if (sq_done) begin
            std_r[sq_r] <= sq_root;
            sq_r        <= sq_r + 2'd1;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r <= 1'b1;
            out_pos_r   <= std_r[0];
            out_vel_r   <= std_r[1];
            out_clk_r   <= std_r[2];
            out_bias_r  <= bias_r;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/kcp_checker.sv
module kcp_checker import kcp_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic signed [DW-1:0] out_bias
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_bias))
    else $error("result changed while stalled");

  // The block works on one item at a time.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in progress");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind kalman_covariance_propagate kcp_checker u_kcp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_bias  (out_chan.clock_bias_error)
);

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import kcp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam logic ACT_INIT = 1'b0;
  localparam logic ACT_PROP = 1'b1;
  localparam int HOLD_CYCLES = 6000;
  localparam int WATCHDOG_LIMIT = 60000;
  localparam logic [STD_W-1:0] MAX63 = {STD_W{1'b1}};

  typedef struct packed {
    logic             action;
    logic [STD_W-1:0] pos_std;
    logic [STD_W-1:0] vel_std;
    logic [STD_W-1:0] bias_std;
    logic [STD_W-1:0] freq_std;
    logic [STD_W-1:0] scale;
    logic [DW-1:0]    freq_noise;
  } cov_item_t;

  typedef struct packed {
    logic [STD_W-1:0] std_pos;
    logic [STD_W-1:0] std_vel;
    logic [STD_W-1:0] std_bias;
    logic [DW-1:0]    bias_err;
  } std_result_t;

  logic clk;
  logic rst_n;

  kcp_in_if  in_ch ();
  kcp_out_if out_ch ();
  kcp_cfg_if cfg_ch ();

  kalman_covariance_propagate dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .cfg_chan (cfg_ch)
  );

  // Model state of the filter.
  logic signed [DW-1:0] cov_p [NS][NS];
  logic signed [DW-1:0] bias_acc;
  logic signed [DW-1:0] prev_freq;
  logic [STD_W-1:0]     noise_reg [7];

  cov_item_t   pending_items [$];
  std_result_t expected_stds [$];
  cov_item_t   cur_item;

  int send_idle_pct;
  int recv_stall_pct;
  logic hold_req;
  int hold_cnt;
  int error_count;
  int quiet_cycles;

  always #4 clk = ~clk;

  function automatic logic signed [DW-1:0] sat_add(logic signed [DW-1:0] a,
                                                   logic signed [DW-1:0] b);
    logic signed [DW:0] s;
    s = {a[DW-1], a} + {b[DW-1], b};
    if (s[DW] != s[DW-1]) return s[DW] ? SMIN : SMAX;
    return s[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] sat_sub(logic signed [DW-1:0] a,
                                                   logic signed [DW-1:0] b);
    logic signed [DW:0] s;
    s = {a[DW-1], a} - {b[DW-1], b};
    if (s[DW] != s[DW-1]) return s[DW] ? SMIN : SMAX;
    return s[DW-1:0];
  endfunction

  // Rounded to nearest with ties away from zero, then saturated.
  function automatic logic signed [DW-1:0] fx_mul(logic signed [DW-1:0] a,
                                                  logic signed [DW-1:0] b);
    logic neg;
    logic [DW-1:0] ma, mb, lim, res;
    logic [2*DW-1:0] p;
    neg = a[DW-1] ^ b[DW-1];
    ma = a[DW-1] ? -a : a;
    mb = b[DW-1] ? -b : b;
    p = {64'b0, ma} * {64'b0, mb};
    p = p + (128'd1 << (FRAC_BITS - 1));
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    if (p[127:96] != 0) res = lim;
    else res = p[95:32];
    if (res > lim) res = lim;
    return neg ? -res : res;
  endfunction

  function automatic logic signed [DW-1:0] variance(logic [STD_W-1:0] sd,
                                                    logic [STD_W-1:0] sc);
    logic signed [DW-1:0] f, s;
    f = sat_add({1'b0, sc}, ONE);
    s = fx_mul({1'b0, sd}, f);
    return fx_mul(s, s);
  endfunction

  function automatic logic [STD_W-1:0] fx_sqrt(logic signed [DW-1:0] x);
    logic [127:0] n, c;
    logic [63:0] r;
    if (x <= 0) return '0;
    n = {64'b0, x} << FRAC_BITS;
    r = '0;
    for (int b = 55; b >= 0; b--) begin
      c = {64'b0, r | (64'd1 << b)};
      if (c * c <= n) r = r | (64'd1 << b);
    end
    return r[STD_W-1:0];
  endfunction

  task automatic propagate_cov(logic signed [DW-1:0] fn);
    logic signed [DW-1:0] phi [NS][NS];
    logic signed [DW-1:0] m [NS][NS];
    logic signed [DW-1:0] t [NS][NS];
    logic signed [DW-1:0] q [NS];
    logic signed [DW-1:0] qh [NS];
    logic signed [DW-1:0] dt, c, half, dt2h, acc;
    dt = {1'b0, noise_reg[CFG_STEP_TIME]};
    c = {1'b0, noise_reg[CFG_INV_CORR]};
    half = dt >>> 1;
    dt2h = fx_mul(dt, dt) >>> 1;
    bias_acc = sat_add(bias_acc, fx_mul(sat_add(fn, prev_freq), half));
    prev_freq = fn;
    for (int i = 0; i < NS; i++)
      for (int j = 0; j < NS; j++)
        phi[i][j] = (i == j) ? ONE : '0;
    phi[0][3] = dt;
    phi[1][4] = dt;
    phi[2][5] = dt;
    phi[6][7] = sat_sub(dt, fx_mul(c, dt2h));
    phi[7][7] = sat_add(sat_sub(ONE, fx_mul(c, dt)), fx_mul(fx_mul(c, c), dt2h));
    for (int i = 0; i < 3; i++) begin
      q[i] = variance(noise_reg[CFG_NOISE_POS], noise_reg[CFG_NOISE_SCALE]);
      q[i+3] = variance(noise_reg[CFG_NOISE_VEL], noise_reg[CFG_NOISE_SCALE]);
    end
    q[6] = variance(noise_reg[CFG_NOISE_BIAS], noise_reg[CFG_NOISE_SCALE]);
    q[7] = variance(noise_reg[CFG_NOISE_FREQ], noise_reg[CFG_NOISE_SCALE]);
    for (int i = 0; i < NS; i++) qh[i] = fx_mul(q[i], half);
    for (int i = 0; i < NS; i++)
      for (int j = 0; j < NS; j++)
        m[i][j] = (i == j) ? sat_add(cov_p[i][j], qh[i]) : cov_p[i][j];
    for (int i = 0; i < NS; i++)
      for (int j = 0; j < NS; j++) begin
        acc = 0;
        for (int k = 0; k < NS; k++) acc = sat_add(acc, fx_mul(phi[i][k], m[k][j]));
        t[i][j] = acc;
      end
    for (int i = 0; i < NS; i++)
      for (int j = 0; j < NS; j++) begin
        acc = 0;
        for (int k = 0; k < NS; k++) acc = sat_add(acc, fx_mul(t[i][k], phi[j][k]));
        if (i == j) acc = sat_add(acc, qh[i]);
        cov_p[i][j] = acc;
      end
  endtask

  task automatic predict_stds(cov_item_t it);
    std_result_t r;
    if (it.action == ACT_INIT) begin
      for (int i = 0; i < NS; i++)
        for (int j = 0; j < NS; j++)
          cov_p[i][j] = '0;
      for (int i = 0; i < 3; i++) begin
        cov_p[i][i] = variance(it.pos_std, it.scale);
        cov_p[i+3][i+3] = variance(it.vel_std, it.scale);
      end
      cov_p[6][6] = variance(it.bias_std, it.scale);
      cov_p[7][7] = variance(it.freq_std, it.scale);
    end else begin
      propagate_cov(it.freq_noise);
    end
    r.std_pos = fx_sqrt(cov_p[0][0]);
    r.std_vel = fx_sqrt(cov_p[3][3]);
    r.std_bias = fx_sqrt(cov_p[6][6]);
    r.bias_err = bias_acc;
    expected_stds.push_back(r);
  endtask

  task automatic report(string what, logic [DW-1:0] got, logic [DW-1:0] want);
    $display("tb: mismatch %s got %h want %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Input driver: predicts each item at its transfer, then offers the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_stds(cur_item);
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_item = pending_items.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.action <= cur_item.action;
          in_ch.init_pos_std <= cur_item.pos_std;
          in_ch.init_vel_std <= cur_item.vel_std;
          in_ch.init_bias_std <= cur_item.bias_std;
          in_ch.init_freq_std <= cur_item.freq_std;
          in_ch.init_scale <= cur_item.scale;
          in_ch.freq_noise <= cur_item.freq_noise;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver with random stalls and an optional long hold-off.
  always @(posedge clk) begin
    if (!hold_req) hold_cnt <= 0;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req && hold_cnt < HOLD_CYCLES) begin
      out_ch.ready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    std_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_stds.size() == 0) begin
        $display("tb: unexpected result at %0t", $realtime);
        error_count++;
      end else begin
        want = expected_stds.pop_front();
        if (out_ch.std_position !== want.std_pos)
          report("std_position", DW'(out_ch.std_position), DW'(want.std_pos));
        if (out_ch.std_velocity !== want.std_vel)
          report("std_velocity", DW'(out_ch.std_velocity), DW'(want.std_vel));
        if (out_ch.std_clock_bias !== want.std_bias)
          report("std_clock_bias", DW'(out_ch.std_clock_bias), DW'(want.std_bias));
        if (out_ch.clock_bias_error !== want.bias_err)
          report("clock_bias_error", out_ch.clock_bias_error, want.bias_err);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic logic [STD_W-1:0] rand_fix();
    case ($urandom_range(5))
      0: return '0;
      1: return MAX63;
      2: return STD_W'({$urandom, $urandom});
      3: return STD_W'($urandom_range(65535)) << $urandom_range(40);
      default: return STD_W'({$urandom_range(7), $urandom});
    endcase
  endfunction

  function automatic cov_item_t make_item(logic act);
    cov_item_t it;
    it.action = act;
    it.pos_std = rand_fix();
    it.vel_std = rand_fix();
    it.bias_std = rand_fix();
    it.freq_std = rand_fix();
    it.scale = ($urandom_range(3) == 0) ? rand_fix() : STD_W'($urandom);
    if ($urandom_range(3) == 0) it.freq_noise = {$urandom, $urandom};
    else it.freq_noise = DW'($signed({$urandom_range(15), $urandom})) - (DW'(1) << 35);
    return it;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [STD_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx != CFG_UNUSED) noise_reg[idx] = val;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() > 0 || in_ch.valid || expected_stds.size() > 0);
    repeat (50) @(posedge clk);
  endtask

  task automatic run_random(int count, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++)
      pending_items.push_back(make_item(($urandom_range(9) < 6) ? ACT_PROP : ACT_INIT));
    wait_drained();
  endtask

  initial begin
    cov_item_t it;
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_INIT;
    in_ch.init_pos_std = '0;
    in_ch.init_vel_std = '0;
    in_ch.init_bias_std = '0;
    in_ch.init_freq_std = '0;
    in_ch.init_scale = '0;
    in_ch.freq_noise = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_NOISE_POS;
    cfg_ch.data = '0;
    hold_req = 1'b0;
    hold_cnt = 0;
    error_count = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    bias_acc = '0;
    prev_freq = '0;
    for (int i = 0; i < 7; i++) noise_reg[i] = '0;
    for (int i = 0; i < NS; i++)
      for (int j = 0; j < NS; j++)
        cov_p[i][j] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items under the all-zero reset configuration first.
    it = make_item(ACT_PROP);
    it.freq_noise = SMAX;
    pending_items.push_back(it);
    it = '0;
    pending_items.push_back(it);
    wait_drained();

    // Typical navigation settings: small dt, moderate noise.
    write_reg(CFG_NOISE_POS, 63'h1_0000_0000);
    write_reg(CFG_NOISE_VEL, 63'h0_4000_0000);
    write_reg(CFG_NOISE_BIAS, 63'h2_0000_0000);
    write_reg(CFG_NOISE_FREQ, 63'h0_1000_0000);
    write_reg(CFG_NOISE_SCALE, 63'h0_8000_0000);
    write_reg(CFG_STEP_TIME, 63'h0_1999_999A);
    write_reg(CFG_INV_CORR, 63'h0_0100_0000);
    write_reg(CFG_UNUSED, MAX63);
    it = '0;
    it.pos_std = 63'h3_0000_0000;
    it.vel_std = 63'h1_0000_0000;
    it.bias_std = 63'h5_0000_0000;
    it.freq_std = 63'h0_8000_0000;
    pending_items.push_back(it);
    it.action = ACT_PROP;
    it.freq_noise = SMIN;
    pending_items.push_back(it);
    it.freq_noise = SMAX;
    pending_items.push_back(it);
    it.freq_noise = ONE;
    pending_items.push_back(it);
    it.freq_noise = -ONE;
    pending_items.push_back(it);
    it = '0;
    it.pos_std = MAX63;
    it.vel_std = MAX63;
    it.bias_std = MAX63;
    it.freq_std = MAX63;
    it.scale = MAX63;
    pending_items.push_back(it);
    it.action = ACT_PROP;
    it.freq_noise = '1;
    pending_items.push_back(it);
    it = '0;
    it.pos_std = 63'd1;
    it.vel_std = 63'd1;
    it.bias_std = 63'd1;
    it.freq_std = 63'd1;
    pending_items.push_back(it);
    for (int i = 0; i < 4; i++) pending_items.push_back(make_item(ACT_PROP));
    wait_drained();
    run_random(100, 0, 0);

    // Receiver holds off while inits keep coming, so the input backs up.
    hold_req <= 1'b1;
    for (int i = 0; i < 8; i++) pending_items.push_back(make_item(ACT_INIT));
    wait (hold_cnt >= HOLD_CYCLES);
    @(posedge clk);
    hold_req <= 1'b0;
    wait_drained();

    run_random(90, 73, 0);

    // Extreme configuration: everything at full scale.
    for (int r = 0; r < 7; r++) write_reg(CFG_IDX_W'(r), MAX63);
    run_random(40, 0, 73);

    write_reg(CFG_STEP_TIME, 63'h0_0000_0001);
    write_reg(CFG_INV_CORR, '0);
    write_reg(CFG_NOISE_SCALE, '0);
    run_random(40, 31, 31);

    // Random configurations.
    for (int p = 0; p < 4; p++) begin
      for (int r = 0; r < 7; r++) write_reg(CFG_IDX_W'(r), rand_fix());
      write_reg(CFG_STEP_TIME, STD_W'($urandom_range(32'h8000_0000)) << $urandom_range(3));
      run_random(55, (p % 2) ? 31 : 0, (p > 1) ? 73 : 0);
    end

    repeat (2000) @(posedge clk);
    if (error_count == 0 && expected_stds.size() == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
